FILE: src/hsps_pkg.sv
// ----------------------------------------------------------------------------
// hsps_pkg: shared types and constants for the height step stencil
// Pixel, column-slice and window types, register codes and stage payload.
// ----------------------------------------------------------------------------
package hsps_pkg;

  localparam int MAX_WIDTH  = 256;  // entries per stored line
  localparam int PIX_W      = 8;
  localparam int ROW_W      = 10;
  localparam int COL_W      = 8;
  localparam int THR_W      = 8;
  localparam int IW_W       = 9;
  localparam int IH_W       = 10;
  localparam int CFG_W      = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int NUM_LINES  = 4;    // stored rows, indexed by row modulo four
  localparam int LINE_IDX_W = 2;
  localparam int WIN        = 5;    // window columns c-2 .. c+2
  localparam int CTR        = 2;    // window column of the centre pixel
  localparam int TAPS       = 8;
  localparam int STEP_MIN   = 3;
  localparam int MIN_DIM    = 5;

  localparam logic [THR_W-1:0] RST_THRESHOLD = 8'd40;
  localparam logic [IW_W-1:0]  RST_WIDTH     = 9'd61;
  localparam logic [IH_W-1:0]  RST_HEIGHT    = 10'd31;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_THRESHOLD = 2'd0,
    REG_IMAGE_WIDTH    = 2'd1,
    REG_IMAGE_HEIGHT   = 2'd2
  } cfg_reg_t;

  typedef logic [PIX_W-1:0] pix_t;
  // One column of the window: element k holds row r-(k+1).
  typedef pix_t [NUM_LINES-1:0] slice_t;
  typedef slice_t [WIN-1:0] win_t;

  typedef struct packed {
    logic shift;  // advance the chain by one column
    logic load;   // take the side load instead of the neighbor
  } cell_ctl_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    pix_t             pix;
    logic             emit;
    logic             interior;
    logic             fend;
  } item_t;

endpackage

FILE: src/hsps_ram.sv
// ----------------------------------------------------------------------------
// hsps_ram: generic single-write, dual-read RAM
// One write port and two read ports, read data registered under read enable.
// ----------------------------------------------------------------------------
module hsps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_a_r <= mem_r[raddr_a];
      rdata_b_r <= mem_r[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

FILE: src/hsps_cell.sv
// ----------------------------------------------------------------------------
// hsps_cell: one column cell of the stencil window
// Holds four stored rows of one column; on shift takes its neighbor's column or the side load.
// ----------------------------------------------------------------------------
module hsps_cell (
  input  logic               clk,
  input  hsps_pkg::cell_ctl_t ctl,
  input  hsps_pkg::slice_t   shift_in,
  input  hsps_pkg::slice_t   load_in,
  output hsps_pkg::slice_t   q
);
  import hsps_pkg::*;

  slice_t q_r;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      q_r <= ctl.load ? load_in : shift_in;
    end
  end

  assign q = q_r;

endmodule

FILE: src/hsps_judge.sv
// ----------------------------------------------------------------------------
// hsps_judge: step verdict for one centre pixel
// Counts diamond neighbors whose absolute difference reaches the threshold.
// ----------------------------------------------------------------------------
module hsps_judge (
  input  hsps_pkg::win_t             win,
  input  hsps_pkg::pix_t             pix,
  input  logic [hsps_pkg::THR_W-1:0] thr,
  output logic                       blocked
);
  import hsps_pkg::*;

  pix_t       centre;
  pix_t       nbr [TAPS];
  logic [TAPS-1:0] hit;
  logic [3:0] hits;

  // Slice element k is row r-(k+1); window column CTR is column c.
  assign centre = win[CTR][1];
  assign nbr[0] = win[CTR][3];
  assign nbr[1] = win[CTR-1][2];
  assign nbr[2] = win[CTR+1][2];
  assign nbr[3] = win[CTR-2][1];
  assign nbr[4] = win[CTR+2][1];
  assign nbr[5] = win[CTR-1][0];
  assign nbr[6] = win[CTR+1][0];
  assign nbr[7] = pix;

  always_comb begin
    for (int i = 0; i < TAPS; i++) begin
      hit[i] = ((centre >= nbr[i]) ? (centre - nbr[i]) : (nbr[i] - centre)) >= thr;
    end
  end

  always_comb begin
    hits = '0;
    for (int i = 0; i < TAPS; i++) begin
      hits = hits + {3'b000, hit[i]};
    end
  end

  assign blocked = hits >= 4'(STEP_MIN);

endmodule

FILE: src/height_step_passability_stencil_core.sv
// ----------------------------------------------------------------------------
// height_step_passability_stencil_core: streaming step marker for height maps
// Marks interior pixels whose diamond neighborhood shows three or more steps.
// ----------------------------------------------------------------------------
// Takes one height pixel per clock in raster order when not stalled, and
// returns the verdict for the pixel two rows up in the same column once rows
// two and later arrive; rows zero and one give no transaction. Stage 1,
// stage 2 and the output register lie between input and out_tvalid. The
// rate is set by the four line RAMs, each read once for the column two ahead
// and once for the current column per pixel, feeding a five-column chain of
// window cells. The line store needs no clearing pass after reset; columns
// of a widened image that were never written read back as arbitrary data.
module height_step_passability_stencil_core (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] height_value
  input  logic        in_tuser,   // [0] frame_start
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [0] blocked, [10:1] out_row, [18:11] out_col
  output logic        out_tlast,  // frame_end
  // configuration
  input  logic                          cfg_we,
  input  logic [hsps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hsps_pkg::CFG_W-1:0]     cfg_wdata
);
  import hsps_pkg::*;

  localparam int RAM_AW = $clog2(MAX_WIDTH);

  logic [THR_W-1:0] thr_r;
  logic [IW_W-1:0]  width_r;
  logic [IH_W-1:0]  height_r;
  logic [IW_W-1:0]  w_eff;
  logic [IH_W-1:0]  h_eff;

  logic [ROW_W-1:0] row_cnt_r, row_cnt_nxt;
  logic [COL_W-1:0] col_cnt_r, col_cnt_nxt;

  logic [ROW_W-1:0] r_a, r_b, r0, r_inc;
  logic [COL_W-1:0] c_a, c0;
  logic [IW_W-1:0]  c_inc;
  logic             wrap_a;
  item_t            item;

  logic  adv, in_accept;
  logic  s1_valid_r, s2_valid_r;
  item_t s1_r, s2_r;

  pix_t      rd_a [NUM_LINES];
  pix_t      rd_b [NUM_LINES];
  slice_t    slice_a, slice_b;
  win_t      win;
  cell_ctl_t cell_ctl [WIN];
  logic      win_shift, load_c;
  logic      judge_blocked;

  logic             out_valid_r, out_blocked_r, out_last_r;
  logic [ROW_W-1:0] out_row_r;
  logic [COL_W-1:0] out_col_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= RST_THRESHOLD;
      width_r  <= RST_WIDTH;
      height_r <= RST_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_STEP_THRESHOLD: thr_r    <= cfg_wdata[THR_W-1:0];
        REG_IMAGE_WIDTH:    width_r  <= cfg_wdata[IW_W-1:0];
        REG_IMAGE_HEIGHT:   height_r <= cfg_wdata[IH_W-1:0];
        default: ;
      endcase
    end
  end

  assign w_eff = (width_r < IW_W'(MIN_DIM))   ? IW_W'(MIN_DIM) :
                 (width_r > IW_W'(MAX_WIDTH)) ? IW_W'(MAX_WIDTH) : width_r;
  assign h_eff = (height_r < IH_W'(MIN_DIM))  ? IH_W'(MIN_DIM) : height_r;

  // All stages move together; a held result stalls every stage and the input.
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;
  assign in_accept = in_tvalid && adv;

  // Position of the incoming pixel and the counters after it
  always_comb begin
    r_a    = in_tuser ? '0 : row_cnt_r;
    c_a    = in_tuser ? '0 : col_cnt_r;
    wrap_a = {1'b0, c_a} >= w_eff;
    r_b    = wrap_a ? r_a + 10'd1 : r_a;
    c0     = wrap_a ? '0 : c_a;
    r0     = (r_b >= h_eff) ? '0 : r_b;
    c_inc  = {1'b0, c0} + 9'd1;
    r_inc  = r0 + 10'd1;
    if (c_inc >= w_eff) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = (r_inc >= h_eff) ? '0 : r_inc;
    end else begin
      col_cnt_nxt = c_inc[COL_W-1:0];
      row_cnt_nxt = r0;
    end
    item.row      = r0;
    item.col      = c0;
    item.pix      = in_tdata;
    item.emit     = r0 >= 10'd2;
    item.interior = (r0 >= 10'd4) && (c0 >= 8'd2) && (({1'b0, c0} + 9'd2) < w_eff);
    item.fend     = (r0 == h_eff - 10'd1) && ({1'b0, c0} == w_eff - 9'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r <= '0;
      col_cnt_r <= '0;
    end else if (in_accept) begin
      row_cnt_r <= row_cnt_nxt;
      col_cnt_r <= col_cnt_nxt;
    end
  end

  // Line store: one RAM per stored row, written at the pixel's column
  for (genvar p = 0; p < NUM_LINES; p++) begin : g_line
    hsps_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
    ) u_line_ram (
      .clk     (clk),
      .we      (in_accept && (r0[LINE_IDX_W-1:0] == LINE_IDX_W'(p))),
      .waddr   (c0[RAM_AW-1:0]),
      .wdata   (in_tdata),
      .re      (in_accept),
      .raddr_a (RAM_AW'(c0 + 8'd2)),
      .raddr_b (c0[RAM_AW-1:0]),
      .rdata_a (rd_a[p]),
      .rdata_b (rd_b[p])
    );
  end

  // Stage 1: rotate RAM data from line order into row-age order
  always_comb begin
    for (int k = 0; k < NUM_LINES; k++) begin
      slice_a[k] = rd_a[LINE_IDX_W'(s1_r.row[LINE_IDX_W-1:0] - LINE_IDX_W'(k + 1))];
      slice_b[k] = rd_b[LINE_IDX_W'(s1_r.row[LINE_IDX_W-1:0] - LINE_IDX_W'(k + 1))];
    end
  end

  // Columns 0 and 1 enter at the centre cell at the start of each row.
  assign win_shift = adv && s1_valid_r;
  assign load_c    = s1_r.col < 8'd2;

  for (genvar i = 0; i < WIN; i++) begin : g_cell
    assign cell_ctl[i].shift = win_shift;
    assign cell_ctl[i].load  = (i == CTR) && load_c;
    if (i == WIN - 1) begin : g_head
      hsps_cell u_cell (
        .clk      (clk),
        .ctl      (cell_ctl[i]),
        .shift_in (slice_a),
        .load_in  (slice_b),
        .q        (win[i])
      );
    end else begin : g_body
      hsps_cell u_cell (
        .clk      (clk),
        .ctl      (cell_ctl[i]),
        .shift_in (win[i+1]),
        .load_in  (slice_b),
        .q        (win[i])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_accept;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_r <= item;
    end
    if (adv && s1_valid_r) begin
      s2_r <= s1_r;
    end
  end

  // Stage 2: verdict from the window
  hsps_judge u_judge (
    .win     (win),
    .pix     (s2_r.pix),
    .thr     (thr_r),
    .blocked (judge_blocked)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s2_valid_r && s2_r.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid_r) begin
      out_blocked_r <= s2_r.interior && judge_blocked;
      out_row_r     <= s2_r.row - 10'd2;
      out_col_r     <= s2_r.col;
      out_last_r    <= s2_r.fend;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b00000, out_col_r, out_row_r, out_blocked_r};
  assign out_tlast  = out_last_r;

`ifndef ASSERT_OFF
  // A frame start places the pixel at row 0, column 0.
  a_frame_start_origin: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_tuser |=> s1_r.row == '0 && s1_r.col == '0)
    else $error("frame start did not restart the position");

  // Pixels in the top two rows or the left two columns are never marked.
  a_border_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_blocked_r |-> out_row_r >= 10'd2 && out_col_r >= 8'd2)
    else $error("border pixel marked as step");

  // A reporting pixel in the last stage yields a transaction.
  a_emit_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s2_valid_r && s2_r.emit |=> out_valid_r)
    else $error("result dropped between stage 2 and output");
`endif

endmodule
